### hdl/wdc_pkg.sv
// Shared constants, command and status types of the windowed delay crossfader.
package wdc_pkg;

    localparam int MAX_WINDOW_DEF = 65536;

    localparam int WL_W    = 17;
    localparam int DELAY_W = 16;
    localparam int CFG_W   = 17;
    localparam int SMP_W   = 16;
    localparam int COEF_W  = 16;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    localparam logic [15:0] WIN_ONE = 16'd16384;

    localparam logic OPC_SAMPLE = 1'b0;
    localparam logic OPC_COEF   = 1'b1;

    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_DELAY         = 1'b1;

    localparam int STEP_CNT_W = 4;
    localparam int MOD_STEPS  = 16;
    localparam int DIV_STEPS  = 15;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR_STEP,
        OP_PREP,
        OP_POS_ZERO,
        OP_MOD_LOAD,
        OP_DIV_STEP,
        OP_POS_REM,
        OP_OLDPOS,
        OP_RD0,
        OP_RD1,
        OP_MUL,
        OP_SUM,
        OP_ABS,
        OP_DIV_LOAD,
        OP_FIN,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        logic   coef_wr;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic wl_zero;
        logic pos_ge_wl;
        logic den_zero;
        logic ovf;
    } dp_status_t;

endpackage

### hdl/wdc_ctrl.sv
// Sequencing state machine of the crossfader: handshakes, step counting and datapath commands.
module wdc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  wdc_pkg::dp_status_t status,
    output wdc_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_POSCHK,
        ST_MOD,
        ST_MODEND,
        ST_OLDPOS,
        ST_RD0,
        ST_RD1,
        ST_MUL,
        ST_SUM,
        ST_ABS,
        ST_CHK,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t                                state_reg, state_next;
    logic [wdc_pkg::STEP_CNT_W-1:0]        cnt_reg, cnt_next;
    logic                                  m_tvalid_reg, m_tvalid_next;
    logic                                  out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.capture   = 1'b0;
        cmd.coef_wr   = 1'b0;
        cmd.op        = wdc_pkg::OP_NONE;
        case (state_reg)
            ST_CLEAR: begin
                cmd.op = wdc_pkg::OP_CLR_STEP;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (s_tuser == wdc_pkg::OPC_COEF) begin
                        cmd.coef_wr = 1'b1;
                    end else begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                cmd.op     = wdc_pkg::OP_PREP;
                state_next = ST_POSCHK;
            end
            ST_POSCHK: begin
                if (status.wl_zero) begin
                    cmd.op     = wdc_pkg::OP_POS_ZERO;
                    state_next = ST_OLDPOS;
                end else if (status.pos_ge_wl) begin
                    cmd.op     = wdc_pkg::OP_MOD_LOAD;
                    cnt_next   = '0;
                    state_next = ST_MOD;
                end else begin
                    state_next = ST_OLDPOS;
                end
            end
            ST_MOD: begin
                cmd.op   = wdc_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == wdc_pkg::STEP_CNT_W'(wdc_pkg::MOD_STEPS - 1)) begin
                    state_next = ST_MODEND;
                end
            end
            ST_MODEND: begin
                cmd.op     = wdc_pkg::OP_POS_REM;
                state_next = ST_OLDPOS;
            end
            ST_OLDPOS: begin
                cmd.op     = wdc_pkg::OP_OLDPOS;
                state_next = ST_RD0;
            end
            ST_RD0: begin
                cmd.op     = wdc_pkg::OP_RD0;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                cmd.op     = wdc_pkg::OP_RD1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.op     = wdc_pkg::OP_MUL;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.op     = wdc_pkg::OP_SUM;
                state_next = ST_ABS;
            end
            ST_ABS: begin
                cmd.op     = wdc_pkg::OP_ABS;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (status.den_zero || status.ovf) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.op     = wdc_pkg::OP_DIV_LOAD;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.op   = wdc_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == wdc_pkg::STEP_CNT_W'(wdc_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.op     = wdc_pkg::OP_FIN;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.op        = wdc_pkg::OP_OUT;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

### hdl/wdc_datapath.sv
// Datapath of the crossfader: registers, window table, delay line, multiplier and serial divider.
module wdc_datapath #(
    parameter int MAX_WINDOW = wdc_pkg::MAX_WINDOW_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [wdc_pkg::CFG_W-1:0]      cfg_data,
    input  logic [wdc_pkg::S_DATA_W-1:0]   s_tdata,
    output logic [wdc_pkg::M_DATA_W-1:0]   m_tdata,
    input  wdc_pkg::dp_cmd_t               cmd,
    output wdc_pkg::dp_status_t            status
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW = $clog2(MAX_WINDOW + 1);

    logic [wdc_pkg::WL_W-1:0]    window_length_reg;
    logic [wdc_pkg::DELAY_W-1:0] delay_reg;
    logic [AW-1:0]               pos_reg;
    logic [AW-1:0]               ptr_reg;
    logic [LW-1:0]               fill_reg;
    logic [AW-1:0]               clr_cnt_reg;

    logic signed [15:0]          sample_reg;
    logic [LW-1:0]               wl_reg;
    logic [LW-1:0]               d_reg;
    logic [AW-1:0]               oldpos_reg;
    logic                        y_valid_reg;
    logic [15:0]                 w0_reg;
    logic signed [15:0]          y_reg;
    logic signed [32:0]          prod_reg;
    logic signed [32:0]          acc_reg;
    logic [16:0]                 den_reg;
    logic [31:0]                 dvd_reg;
    logic                        neg_reg;
    logic [16:0]                 rem_reg;
    logic [15:0]                 shf_reg;
    logic [16:0]                 div_reg;
    logic [15:0]                 res_reg;
    logic [15:0]                 m_tdata_reg;

    logic [15:0]                 tbl_mem [MAX_WINDOW];
    logic [15:0]                 dl_mem [MAX_WINDOW];
    logic [15:0]                 tbl_rdata_reg;
    logic [15:0]                 dl_rdata_reg;

    logic [wdc_pkg::SMP_W-1:0]   in_sample;
    logic [15:0]                 in_index;
    logic [wdc_pkg::COEF_W-1:0]  in_coef;

    logic                        tbl_we;
    logic [AW-1:0]               tbl_waddr;
    logic [15:0]                 tbl_wdata;
    logic                        tbl_re;
    logic [AW-1:0]               tbl_raddr;
    logic                        dl_en;

    logic [LW-1:0]               wl_cap;
    logic [LW-1:0]               d_cap;
    logic [LW-1:0]               pos_ext;
    logic [LW-1:0]               ptr_ext;
    logic [LW-1:0]               ptr_inc;
    logic [LW-1:0]               pos_inc;
    logic [LW:0]                 wrap_sum;
    logic signed [33:0]          mul_out;
    logic signed [16:0]          mul_a;
    logic [15:0]                 mul_b;
    logic [32:0]                 mag;
    logic [17:0]                 div_t;
    logic                        div_ge;

    assign in_sample = s_tdata[15:0];
    assign in_index  = s_tdata[31:16];
    assign in_coef   = s_tdata[47:32];

    assign wl_cap  = (window_length_reg > wdc_pkg::WL_W'(MAX_WINDOW)) ?
                     LW'(MAX_WINDOW) : LW'(window_length_reg);
    assign d_cap   = ({1'b0, delay_reg} > wdc_pkg::WL_W'(wl_cap)) ? wl_cap : LW'(delay_reg);
    assign pos_ext = LW'(pos_reg);
    assign ptr_ext = LW'(ptr_reg);
    assign ptr_inc = ptr_ext + 1'b1;
    assign pos_inc = pos_ext + 1'b1;
    assign wrap_sum = (LW + 1)'(pos_reg) + (LW + 1)'(wl_reg) - (LW + 1)'(d_reg);

    assign mul_a   = (cmd.op == wdc_pkg::OP_RD1) ? 17'(sample_reg) : 17'(y_reg);
    assign mul_b   = tbl_rdata_reg;
    assign mul_out = mul_a * $signed({1'b0, mul_b});

    assign mag     = acc_reg[32] ? 33'(-acc_reg) : 33'(acc_reg);

    assign div_t   = {rem_reg, shf_reg[15]};
    assign div_ge  = div_t >= {1'b0, div_reg};

    assign status.clr_last  = (clr_cnt_reg == AW'(MAX_WINDOW - 1));
    assign status.wl_zero   = (wl_reg == '0);
    assign status.pos_ge_wl = (pos_ext >= wl_reg);
    assign status.den_zero  = (den_reg == '0);
    assign status.ovf       = (dvd_reg >= {den_reg, 15'b0});

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = clr_cnt_reg;
        tbl_wdata = wdc_pkg::WIN_ONE;
        if (cmd.op == wdc_pkg::OP_CLR_STEP) begin
            tbl_we = 1'b1;
        end else if (cmd.coef_wr && ({1'b0, in_index} < 17'(MAX_WINDOW))) begin
            tbl_we    = 1'b1;
            tbl_waddr = AW'(in_index);
            tbl_wdata = in_coef;
        end
    end

    assign tbl_re    = (cmd.op == wdc_pkg::OP_RD0) || (cmd.op == wdc_pkg::OP_RD1);
    assign tbl_raddr = (cmd.op == wdc_pkg::OP_RD0) ? pos_reg : oldpos_reg;
    assign dl_en     = (cmd.op == wdc_pkg::OP_RD0) && (d_reg != '0);

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            tbl_rdata_reg <= tbl_mem[tbl_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (dl_en) begin
            dl_rdata_reg     <= dl_mem[ptr_reg];
            dl_mem[ptr_reg]  <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= '0;
            delay_reg         <= '0;
            pos_reg           <= '0;
            ptr_reg           <= '0;
            fill_reg          <= '0;
            clr_cnt_reg       <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    wdc_pkg::REG_WINDOW_LENGTH: begin
                        window_length_reg <= cfg_data;
                    end
                    wdc_pkg::REG_DELAY: begin
                        delay_reg <= cfg_data[wdc_pkg::DELAY_W-1:0];
                        ptr_reg   <= '0;
                        fill_reg  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            case (cmd.op)
                wdc_pkg::OP_CLR_STEP: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                wdc_pkg::OP_POS_ZERO: begin
                    pos_reg <= '0;
                end
                wdc_pkg::OP_POS_REM: begin
                    pos_reg <= AW'(rem_reg);
                end
                wdc_pkg::OP_OLDPOS: begin
                    if (d_reg != '0 && ptr_ext >= d_reg) begin
                        ptr_reg <= '0;
                    end
                end
                wdc_pkg::OP_RD0: begin
                    if (d_reg != '0) begin
                        if (ptr_ext == fill_reg) begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        ptr_reg <= (ptr_inc >= d_reg) ? '0 : AW'(ptr_inc);
                    end
                end
                wdc_pkg::OP_OUT: begin
                    if (wl_reg != '0 && pos_inc >= wl_reg) begin
                        pos_reg <= '0;
                    end else begin
                        pos_reg <= AW'(pos_inc);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= $signed(in_sample);
        end
        case (cmd.op)
            wdc_pkg::OP_PREP: begin
                wl_reg <= wl_cap;
                d_reg  <= d_cap;
            end
            wdc_pkg::OP_MOD_LOAD: begin
                rem_reg <= '0;
                shf_reg <= 16'(pos_reg);
                div_reg <= 17'(wl_reg);
            end
            wdc_pkg::OP_DIV_LOAD: begin
                rem_reg <= dvd_reg[31:15];
                shf_reg <= {dvd_reg[14:0], 1'b0};
                div_reg <= den_reg;
            end
            wdc_pkg::OP_DIV_STEP: begin
                rem_reg <= div_ge ? 17'(div_t - {1'b0, div_reg}) : div_t[16:0];
                shf_reg <= {shf_reg[14:0], div_ge};
            end
            wdc_pkg::OP_OLDPOS: begin
                oldpos_reg <= (pos_ext >= d_reg) ? AW'(pos_ext - d_reg) : AW'(wrap_sum);
            end
            wdc_pkg::OP_RD0: begin
                y_valid_reg <= (d_reg != '0) && (ptr_ext < fill_reg);
            end
            wdc_pkg::OP_RD1: begin
                w0_reg   <= tbl_rdata_reg;
                prod_reg <= mul_out[32:0];
                y_reg    <= y_valid_reg ? $signed(dl_rdata_reg) : 16'sd0;
            end
            wdc_pkg::OP_MUL: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_out[32:0];
                den_reg  <= 17'(w0_reg) + 17'(tbl_rdata_reg);
            end
            wdc_pkg::OP_SUM: begin
                acc_reg <= acc_reg + prod_reg;
            end
            wdc_pkg::OP_ABS: begin
                neg_reg <= acc_reg[32];
                dvd_reg <= mag[31:0] + 32'(den_reg[16:1]);
            end
            wdc_pkg::OP_FIN: begin
                if (status.den_zero) begin
                    res_reg <= '0;
                end else if (status.ovf) begin
                    res_reg <= neg_reg ? 16'h8000 : 16'h7FFF;
                end else begin
                    res_reg <= neg_reg ? 16'(-{1'b0, shf_reg[14:0]}) : {1'b0, shf_reg[14:0]};
                end
            end
            wdc_pkg::OP_OUT: begin
                m_tdata_reg <= res_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_tdata = m_tdata_reg;

endmodule

### hdl/windowed_delay_crossfade.sv
// Top level of the windowed delay crossfader: controller and datapath.
//
//  Channel  Ports                      Contents
//  input    s_tvalid/s_tready/s_tdata  tdata: sample_in, coef_index, coef_value; tuser: opcode
//  output   m_tvalid/m_tready/m_tdata  tdata: sample_out
//  config   cfg_we/cfg_index/cfg_data  0 window_length, 1 delay
//
// A sample uses two sequential window table reads and the 15-step serial divider; its result is
// offered once the output register is free, and s_tready returns as m_tvalid rises: no new item
// is taken until the sample is done, but the result waits in the output register while the next
// one is accepted. Reducing the position after the window length shrank adds a modulo pass on
// the divider; a zero weight sum or a saturated result skips the divider. After reset a clearing
// pass fills the window table; s_tready stays low.
module windowed_delay_crossfade #(
    parameter int MAX_WINDOW = wdc_pkg::MAX_WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // bits from lowest: sample_in[15:0], coef_index[31:16], coef_value[47:32]
    input  logic [wdc_pkg::S_DATA_W-1:0]  s_tdata,
    // bit 0: opcode
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bits from lowest: sample_out[15:0]
    output logic [wdc_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [wdc_pkg::CFG_W-1:0]     cfg_data
);

    wdc_pkg::dp_cmd_t    cmd;
    wdc_pkg::dp_status_t status;

    wdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wdc_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### dv/wdc_checker.sv
// Checker for the windowed delay crossfader: predicts every output sample and compares it.
module wdc_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [wdc_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [wdc_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [wdc_pkg::CFG_W-1:0]    cfg_data,
    output int                           errors,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] win_tab [wdc_pkg::MAX_WINDOW_DEF];
    logic [15:0] tap_line [wdc_pkg::MAX_WINDOW_DEF];
    int unsigned tap_ptr = 0;
    int unsigned win_pos = 0;
    int unsigned cfg_wlen = 0;
    int unsigned cfg_delay = 0;
    logic [15:0] expected_out_q [$];
    int fail_cnt = 0;

    function automatic void clear_taps();
        foreach (tap_line[i]) tap_line[i] = '0;
        tap_ptr = 0;
    endfunction

    function automatic logic [15:0] mix_sample(logic [15:0] x_raw);
        int unsigned wl;
        int unsigned d;
        int unsigned old_pos;
        longint x;
        longint y;
        longint num;
        longint den;
        longint mag;
        longint q;
        wl = (cfg_wlen > wdc_pkg::MAX_WINDOW_DEF) ? wdc_pkg::MAX_WINDOW_DEF : cfg_wlen;
        d = (cfg_delay > wl) ? wl : cfg_delay;
        x = longint'($signed(x_raw));
        if (wl == 0) begin
            win_pos = 0;
            old_pos = 0;
        end else begin
            win_pos = win_pos % wl;
            old_pos = (win_pos >= d) ? win_pos - d : win_pos + wl - d;
        end
        y = 0;
        if (d != 0) begin
            if (tap_ptr >= d) tap_ptr = 0;
            y = longint'($signed(tap_line[tap_ptr]));
            tap_line[tap_ptr] = x_raw;
            tap_ptr++;
            if (tap_ptr >= d) tap_ptr = 0;
        end
        num = x * longint'(win_tab[win_pos]) + y * longint'(win_tab[old_pos]);
        den = longint'(win_tab[win_pos]) + longint'(win_tab[old_pos]);
        if (den == 0) begin
            q = 0;
        end else begin
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            if (num < 0) q = -q;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
        end
        win_pos++;
        if (wl != 0 && win_pos >= wl) win_pos = 0;
        return q[15:0];
    endfunction

    always @(posedge aclk) begin
        logic [15:0] want;
        if (!aresetn) begin
            foreach (win_tab[i]) win_tab[i] = wdc_pkg::WIN_ONE;
            clear_taps();
            win_pos = 0;
            cfg_wlen = 0;
            cfg_delay = 0;
            expected_out_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_out_q.size() == 0) begin
                    $error("sample_out: no transaction expected, got %0d", $signed(m_tdata));
                    fail_cnt++;
                end else begin
                    want = expected_out_q.pop_front();
                    if (m_tdata !== want) begin
                        $error("sample_out: expected %0d, got %0d",
                               $signed(want), $signed(m_tdata));
                        fail_cnt++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == wdc_pkg::REG_WINDOW_LENGTH) begin
                    cfg_wlen = cfg_data;
                end else begin
                    cfg_delay = cfg_data[wdc_pkg::DELAY_W-1:0];
                    clear_taps();
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == wdc_pkg::OPC_COEF) begin
                    win_tab[s_tdata[31:16]] = s_tdata[47:32];
                end else begin
                    expected_out_q.push_back(mix_sample(s_tdata[15:0]));
                end
            end
        end
        pending <= expected_out_q.size();
        errors <= fail_cnt;
    end

endmodule

### dv/tb_top.sv
// Top of the crossfader testbench: clock, reset, stimulus, output back-pressure and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    // bits from lowest: sample_in[15:0], coef_index[31:16], coef_value[47:32]
    logic [wdc_pkg::S_DATA_W-1:0] s_tdata = '0;
    // bit 0: opcode
    logic                         s_tuser = wdc_pkg::OPC_SAMPLE;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    // bits from lowest: sample_out[15:0]
    logic [wdc_pkg::M_DATA_W-1:0] m_tdata;
    logic                         cfg_we = 1'b0;
    logic                         cfg_index = wdc_pkg::REG_WINDOW_LENGTH;
    logic [wdc_pkg::CFG_W-1:0]    cfg_data = '0;

    int fail_total;
    int outstanding;
    bit calm = 1'b0;
    int stall_asks = 0;
    int stall_served = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    windowed_delay_crossfade dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    wdc_checker checker_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .errors   (fail_total),
        .pending  (outstanding)
    );

    task automatic push_item(logic opc, logic [15:0] smp, logic [15:0] idx, logic [15:0] val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= opc;
        s_tdata <= {val, idx, smp};
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic push_sample(logic [15:0] smp);
        push_item(wdc_pkg::OPC_SAMPLE, smp, 16'($urandom), 16'($urandom));
    endtask

    task automatic push_coef(logic [15:0] idx, logic [15:0] val);
        push_item(wdc_pkg::OPC_COEF, 16'($urandom), idx, val);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        while (s_tready !== 1'b1) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= wdc_pkg::CFG_W'(val);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic random_item(int unsigned wl_eff);
        logic [15:0] idx;
        logic [15:0] v;
        if ($urandom_range(0, 4) == 0) begin
            if (wl_eff == 0 || $urandom_range(0, 3) == 0) begin
                idx = 16'($urandom);
            end else begin
                idx = 16'($urandom_range(0, wl_eff - 1));
            end
            case ($urandom_range(0, 7))
                0: v = '0;
                1: v = wdc_pkg::WIN_ONE;
                2: v = 16'hFFFF;
                default: v = 16'($urandom);
            endcase
            push_coef(idx, v);
        end else begin
            case ($urandom_range(0, 9))
                0: v = 16'h7FFF;
                1: v = 16'h8000;
                default: v = 16'($urandom);
            endcase
            push_sample(v);
        end
    endtask

    task automatic run_phase(int unsigned wl, int unsigned dly, bit set_delay, int count,
                             bit quiet, bit hold_out, bit midway_pause);
        int unsigned wl_eff;
        write_reg(wdc_pkg::REG_WINDOW_LENGTH, wl);
        if (set_delay) write_reg(wdc_pkg::REG_DELAY, dly);
        calm = quiet;
        if (hold_out) stall_asks++;
        wl_eff = (wl > wdc_pkg::MAX_WINDOW_DEF) ? wdc_pkg::MAX_WINDOW_DEF : wl;
        for (int n = 0; n < count; n++) begin
            if (midway_pause && n == count / 2) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (outstanding != 0) @(posedge aclk);
            end
            random_item(wl_eff);
        end
        settle();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(wdc_pkg::REG_WINDOW_LENGTH, 0);
        write_reg(wdc_pkg::REG_DELAY, 0);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0000);
        push_sample(16'hFFFF);
        push_sample(16'h0001);
        push_sample(16'h5555);
        push_sample(16'hAAAA);
        push_coef(16'h0000, 16'h0000);
        push_sample(16'd1234);
        push_coef(16'hFFFF, 16'hFFFF);
        push_coef(16'h0000, 16'hFFFF);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        settle();

        write_reg(wdc_pkg::REG_WINDOW_LENGTH, 4);
        write_reg(wdc_pkg::REG_DELAY, 2);
        push_coef(16'd0, wdc_pkg::WIN_ONE);
        push_coef(16'd1, 16'h0000);
        push_coef(16'd2, 16'hFFFF);
        push_coef(16'd3, 16'h0001);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'd100);
        push_sample(-16'sd100);
        settle();

        run_phase(16, 5, 1'b1, 50, 1'b0, 1'b0, 1'b0);
        run_phase(40, 20, 1'b1, 40, 1'b1, 1'b1, 1'b0);
        run_phase(5, 0, 1'b0, 40, 1'b0, 1'b0, 1'b0);
        run_phase(131071, 65535, 1'b1, 30, 1'b0, 1'b0, 1'b0);
        run_phase(65536, 100, 1'b1, 40, 1'b0, 1'b0, 1'b1);
        run_phase(1, 1, 1'b1, 30, 1'b0, 1'b0, 1'b0);
        run_phase(3, 65535, 1'b1, 40, 1'b1, 1'b0, 1'b0);
        run_phase(0, 7, 1'b1, 30, 1'b0, 1'b0, 1'b0);
        run_phase(24, 24, 1'b1, 50, 1'b0, 1'b0, 1'b0);
        run_phase(10, 0, 1'b1, 40, 1'b0, 1'b0, 1'b0);

        if (fail_total == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        int gap;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 12);
            if (stall_served != stall_asks) begin
                gap = 400;
                stall_served++;
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end

endmodule
